// ===== hdl/eth_arp_ipv4_rx_classifier_macros.svh =====
// assertion macros for the rx classifier
`ifndef ETH_ARP_IPV4_RX_CLASSIFIER_MACROS_SVH
`define ETH_ARP_IPV4_RX_CLASSIFIER_MACROS_SVH
`define EARC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define EARC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ===== hdl/earc_pkg.sv =====
package earc_pkg;
  localparam int CacheEntries = 4;
  localparam int CacheIdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int MaxFrameLen = 2048;
  localparam int CountW = $clog2(MaxFrameLen + 1);
  localparam logic [15:0] EtArp = 16'h0806;
  localparam logic [15:0] EtIpv4 = 16'h0800;
  localparam logic [15:0] EchoId = 16'h4F53;
  localparam logic [31:0] LocalIpReset = 32'h0A00020F;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_ARM = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    V_SHORT = 4'd0, V_ARP = 4'd1, V_ARP_SHORT = 4'd2, V_NOT_IP = 4'd3,
    V_BAD_LEN = 4'd4, V_NOT_OURS = 4'd5, V_ICMP = 4'd6, V_UDP = 4'd7,
    V_TCP = 4'd8, V_OTHER = 4'd9, V_LOOKUP = 4'd10
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LEARN, S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic last;
    logic [31:0] query_ip;
  } in_item_t;

  typedef struct packed {
    logic [3:0] verdict;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic send_arp_reply;
    logic echo_matched;
    logic [6:0] payload_offset;
    logic [11:0] payload_len;
    logic lookup_hit;
    logic [47:0] lookup_mac;
    logic echo_waiting;
    logic [31:0] frames_seen;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [31:0] ip;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic [CacheIdxW-1:0] hit_idx;
    logic [47:0] hit_mac;
    logic free_found;
    logic [CacheIdxW-1:0] free_idx;
  } scan_rsp_t;
endpackage

// ===== hdl/earc_cache.sv =====
module earc_cache (
  input logic clk,
  input logic rst,
  input earc_pkg::scan_req_t req,
  output earc_pkg::scan_rsp_t rsp,
  input logic wr_en,
  input logic [earc_pkg::CacheIdxW-1:0] wr_idx,
  input logic [31:0] wr_ip,
  input logic [47:0] wr_mac
);
  import earc_pkg::*;
  logic [31:0] ip_mem [CacheEntries];
  logic [47:0] mac_mem [CacheEntries];
  logic [CacheEntries-1:0] valid;
  logic busy;
  logic [CacheIdxW:0] idx;
  logic [31:0] key;
  logic [CacheIdxW-1:0] cur;

  assign cur = idx[CacheIdxW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[wr_idx] <= wr_ip;
      mac_mem[wr_idx] <= wr_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      busy <= 1'b0;
      rsp <= '0;
      idx <= '0;
      key <= '0;
    end else begin
      if (wr_en) valid[wr_idx] <= 1'b1;
      if (req.start) begin
        busy <= 1'b1;
        idx <= '0;
        key <= req.ip;
        rsp.done <= 1'b0;
        rsp.hit <= 1'b0;
        rsp.free_found <= 1'b0;
        rsp.hit_idx <= '0;
        rsp.free_idx <= '0;
        rsp.hit_mac <= '0;
      end else if (busy) begin
        if (valid[cur] && ip_mem[cur] == key) begin
          rsp.hit <= 1'b1;
          rsp.hit_idx <= cur;
          rsp.hit_mac <= mac_mem[cur];
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end else if (!valid[cur]) begin
          rsp.free_found <= 1'b1;
          rsp.free_idx <= cur;
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end else if (idx == (CacheIdxW + 1)'(CacheEntries - 1)) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
          rsp.done <= 1'b0;
        end
      end else begin
        rsp.done <= 1'b0;
      end
    end
  end
endmodule

// ===== hdl/eth_arp_ipv4_rx_classifier.sv =====
// channel   direction  payload     transfer when
// in        input      in_item_t   in_valid && in_ready
// out       output     out_item_t  out_valid && out_ready
// cfg       input      local_ip    cfg_we
// a frame byte without last and ops 1 and 3 are taken in S_IDLE without a cache scan
// a last byte or a lookup goes through the serial cache scan, then through S_LEARN
// when a frame's address is learned, then waits in the output register until taken
// in_ready is low from the start of the scan until the result transfers
// rst is synchronous and clears the cache valid bits, flags and counters at once
module eth_arp_ipv4_rx_classifier (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input earc_pkg::in_item_t in_data,
  output logic out_valid,
  input logic out_ready,
  output earc_pkg::out_item_t out_data,
  input logic cfg_we,
  input logic [31:0] cfg_data
);
  import earc_pkg::*;
  state_t state, state_next;
  logic [31:0] local_ip;
  logic [CountW-1:0] byte_count;
  logic [31:0] frame_counter;
  logic wait_flag;
  logic [31:0] wait_target;
  logic [47:0] eth_mac;
  logic [15:0] eth_type;
  logic [15:0] arp_op;
  logic [47:0] arp_smac;
  logic [31:0] arp_sip, arp_tip;
  logic [3:0] ip_ihl;
  logic [15:0] ip_len;
  logic [7:0] ip_proto;
  logic [31:0] ip_src, ip_dst;
  logic [7:0] icmp_type;
  logic [15:0] icmp_id;
  out_item_t res;
  logic [31:0] learn_ip;
  logic [47:0] learn_mac;
  logic is_lookup;
  scan_req_t req;
  scan_rsp_t rsp;
  logic wr_en;
  logic [CacheIdxW-1:0] wr_idx;
  logic acc;
  logic [CountW-1:0] pos;
  logic [6:0] off;
  logic [5:0] hl;
  out_item_t cls;
  logic cls_learn, cls_clear;
  out_item_t lk_res, fr_res;

  assign acc = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = res;
  assign pos = byte_count;
  assign hl = {ip_ihl, 2'b00};
  assign off = 7'd14 + {1'b0, hl};

  earc_cache u_cache (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .wr_en(wr_en), .wr_idx(wr_idx), .wr_ip(learn_ip), .wr_mac(learn_mac)
  );

  always_comb begin
    logic [12:0] len13;
    logic [16:0] need;
    cls = '0;
    cls_learn = 1'b0;
    cls_clear = 1'b0;
    len13 = 13'(byte_count);
    need = 17'd14 + 17'(ip_len);
    if (len13 < 13'd14) begin
      cls.verdict = V_SHORT;
    end else if (eth_type == EtArp) begin
      if (len13 < 13'd42) begin
        cls.verdict = V_ARP_SHORT;
      end else begin
        cls.verdict = V_ARP;
        cls.src_ip = arp_sip;
        cls.src_mac = arp_smac;
        cls_learn = (arp_op == 16'd1) || (arp_op == 16'd2);
        cls.send_arp_reply = (arp_op == 16'd1) && (arp_tip == local_ip);
      end
    end else if (eth_type != EtIpv4) begin
      cls.verdict = V_NOT_IP;
    end else if (len13 < 13'd34 || hl < 6'd20 || len13 < 13'(off) ||
                 ip_len < 16'(hl) || need > 17'(len13)) begin
      cls.verdict = V_BAD_LEN;
    end else begin
      cls.src_ip = ip_src;
      cls.src_mac = eth_mac;
      cls.payload_offset = off;
      cls.payload_len = 12'(ip_len - 16'(hl));
      if (ip_dst != local_ip) begin
        cls.verdict = V_NOT_OURS;
      end else begin
        cls_learn = 1'b1;
        unique case (ip_proto)
          8'd1: begin
            cls.verdict = V_ICMP;
            if ((ip_len - 16'(hl)) >= 16'd8 && icmp_type == 8'd0 && wait_flag &&
                ip_src == wait_target && icmp_id == EchoId) begin
              cls_clear = 1'b1;
              cls.echo_matched = 1'b1;
            end
          end
          8'd17: cls.verdict = V_UDP;
          8'd6: cls.verdict = V_TCP;
          default: cls.verdict = V_OTHER;
        endcase
      end
    end
  end

  always_comb begin
    lk_res = '0;
    lk_res.verdict = V_LOOKUP;
    lk_res.lookup_hit = rsp.hit;
    lk_res.lookup_mac = rsp.hit ? rsp.hit_mac : '0;
    lk_res.echo_waiting = wait_flag;
    lk_res.frames_seen = frame_counter;
    fr_res = cls;
    fr_res.echo_waiting = wait_flag && !cls_clear;
    fr_res.frames_seen = frame_counter + 1'b1;
  end

  always_comb begin
    state_next = state;
    req = '0;
    wr_en = 1'b0;
    wr_idx = rsp.free_found ? rsp.free_idx : (rsp.hit ? rsp.hit_idx : '0);
    unique case (state)
      S_IDLE: begin
        if (acc && (in_data.op == OP_LOOKUP ||
            (in_data.op == OP_BYTE && in_data.last))) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rsp.done) state_next = (cls_learn && !is_lookup) ? S_LEARN : S_OUT;
      end
      S_LEARN: begin
        wr_en = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_IDLE && state_next == S_SCAN) begin
      req.start = 1'b1;
      req.ip = (in_data.op == OP_LOOKUP) ? in_data.query_ip :
               ((eth_type == EtArp) ? arp_sip : ip_src);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= LocalIpReset;
      byte_count <= '0;
      frame_counter <= '0;
      wait_flag <= 1'b0;
      wait_target <= '0;
      eth_mac <= '0; eth_type <= '0; arp_op <= '0; arp_smac <= '0;
      arp_sip <= '0; arp_tip <= '0; ip_ihl <= '0; ip_len <= '0;
      ip_proto <= '0; ip_src <= '0; ip_dst <= '0; icmp_type <= '0; icmp_id <= '0;
      is_lookup <= 1'b0;
    end else begin
      if (cfg_we) local_ip <= cfg_data;
      if (state == S_IDLE && acc) begin
        unique case (op_t'(in_data.op))
          OP_ARM: begin
            wait_target <= in_data.query_ip;
            wait_flag <= 1'b1;
          end
          OP_CANCEL: wait_flag <= 1'b0;
          OP_LOOKUP: is_lookup <= 1'b1;
          OP_BYTE: begin
            is_lookup <= 1'b0;
            if (!in_data.last && byte_count < CountW'(MaxFrameLen)) begin
              byte_count <= byte_count + 1'b1;
            end
            if (byte_count < CountW'(MaxFrameLen)) begin
              if (pos >= 6 && pos <= 11) eth_mac[8*(11-pos) +: 8] <= in_data.data_byte;
              if (pos == 12) eth_type[15:8] <= in_data.data_byte;
              if (pos == 13) eth_type[7:0] <= in_data.data_byte;
              if (pos == 20) arp_op[15:8] <= in_data.data_byte;
              if (pos == 21) arp_op[7:0] <= in_data.data_byte;
              if (pos >= 22 && pos <= 27) arp_smac[8*(27-pos) +: 8] <= in_data.data_byte;
              if (pos >= 28 && pos <= 31) arp_sip[8*(31-pos) +: 8] <= in_data.data_byte;
              if (pos >= 38 && pos <= 41) arp_tip[8*(41-pos) +: 8] <= in_data.data_byte;
              if (pos == 14) ip_ihl <= in_data.data_byte[3:0];
              if (pos == 16) ip_len[15:8] <= in_data.data_byte;
              if (pos == 17) ip_len[7:0] <= in_data.data_byte;
              if (pos == 23) ip_proto <= in_data.data_byte;
              if (pos >= 26 && pos <= 29) ip_src[8*(29-pos) +: 8] <= in_data.data_byte;
              if (pos >= 30 && pos <= 33) ip_dst[8*(33-pos) +: 8] <= in_data.data_byte;
              if (pos >= 14) begin
                if (pos == CountW'(off)) icmp_type <= in_data.data_byte;
                if (pos == CountW'(off) + 4) icmp_id[15:8] <= in_data.data_byte;
                if (pos == CountW'(off) + 5) icmp_id[7:0] <= in_data.data_byte;
              end
            end
            if (in_data.last && byte_count < CountW'(MaxFrameLen)) begin
              byte_count <= byte_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (state == S_SCAN && rsp.done) begin
        if (is_lookup) begin
          res <= lk_res;
        end else begin
          res <= fr_res;
          frame_counter <= frame_counter + 1'b1;
          if (cls_clear) wait_flag <= 1'b0;
          learn_ip <= (eth_type == EtArp) ? arp_sip : ip_src;
          learn_mac <= (eth_type == EtArp) ? arp_smac : eth_mac;
          byte_count <= '0;
          eth_mac <= '0; eth_type <= '0; arp_op <= '0; arp_smac <= '0;
          arp_sip <= '0; arp_tip <= '0; ip_ihl <= '0; ip_len <= '0;
          ip_proto <= '0; ip_src <= '0; ip_dst <= '0; icmp_type <= '0; icmp_id <= '0;
        end
      end
    end
  end
endmodule

// ===== hdl/earc_checker.sv =====
module earc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input earc_pkg::out_item_t out_data
);
  import earc_pkg::*;
`include "eth_arp_ipv4_rx_classifier_macros.svh"
  `EARC_ASSERT(no_ready_while_out, clk, rst, out_valid |-> !in_ready)
  `EARC_ASSERT(out_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
  `EARC_ASSERT(verdict_range, clk, rst, out_valid |-> (out_data.verdict <= V_LOOKUP))
  `EARC_ASSERT_NR(reset_quiet, clk, $past(rst) |-> !out_valid)
endmodule

bind eth_arp_ipv4_rx_classifier earc_checker u_earc_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/tb_eth_arp_ipv4_rx_classifier.sv =====
`timescale 1ns / 1ps
module tb_eth_arp_ipv4_rx_classifier;
  import earc_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int verdicts_checked = 0;
  int idle_cycles = 0;

  // shadow of the block state
  logic [31:0] m_cache_ip [CacheEntries];
  logic [47:0] m_cache_mac [CacheEntries];
  logic m_cache_valid [CacheEntries];
  logic m_wait_flag;
  logic [31:0] m_wait_target;
  int m_byte_count;
  logic [31:0] m_frame_counter;
  logic [63:0] m_eth;
  logic [63:0] m_arp0, m_arp1, m_ip0, m_ip1;
  logic [23:0] m_icmp;
  logic [31:0] m_local_ip;

  out_item_t expected_verdicts[$];

  eth_arp_ipv4_rx_classifier dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  task automatic clear_frame_fields();
    m_byte_count = 0;
    m_eth = '0;
    m_arp0 = '0;
    m_arp1 = '0;
    m_ip0 = '0;
    m_ip1 = '0;
    m_icmp = '0;
  endtask

  task automatic model_reset();
    for (int i = 0; i < CacheEntries; i++) begin
      m_cache_ip[i] = '0;
      m_cache_mac[i] = '0;
      m_cache_valid[i] = 1'b0;
    end
    m_wait_flag = 1'b0;
    m_wait_target = '0;
    m_frame_counter = '0;
    m_local_ip = LocalIpReset;
    clear_frame_fields();
  endtask

  function automatic void put8(ref logic [63:0] w, input int lsb, input logic [7:0] b);
    w[lsb +: 8] = b;
  endfunction

  task automatic capture_byte(int pos, logic [7:0] b);
    int off;
    if (pos >= 6 && pos <= 11) put8(m_eth, 16 + 8 * (11 - pos), b);
    if (pos == 12 || pos == 13) put8(m_eth, 8 * (13 - pos), b);
    if (pos == 20 || pos == 21) put8(m_arp1, 48 + 8 * (21 - pos), b);
    if (pos >= 22 && pos <= 27) put8(m_arp1, 8 * (27 - pos), b);
    if (pos >= 28 && pos <= 31) put8(m_arp0, 32 + 8 * (31 - pos), b);
    if (pos >= 38 && pos <= 41) put8(m_arp0, 8 * (41 - pos), b);
    if (pos == 14) put8(m_ip1, 24, b);
    if (pos == 16 || pos == 17) put8(m_ip1, 8 + 8 * (17 - pos), b);
    if (pos == 23) put8(m_ip1, 0, b);
    if (pos >= 26 && pos <= 29) put8(m_ip0, 32 + 8 * (29 - pos), b);
    if (pos >= 30 && pos <= 33) put8(m_ip0, 8 * (33 - pos), b);
    if (pos >= 14) begin
      off = 14 + int'(m_ip1[27:24]) * 4;
      if (pos == off) m_icmp[23:16] = b;
      if (pos == off + 4) m_icmp[15:8] = b;
      if (pos == off + 5) m_icmp[7:0] = b;
    end
  endtask

  task automatic learn_addr(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = 0;
    for (int i = 0; i < CacheEntries; i++) begin
      if (m_cache_valid[i] && m_cache_ip[i] == ip) begin
        m_cache_mac[i] = mac;
        return;
      end
      if (!m_cache_valid[i]) begin
        slot = i;
        break;
      end
    end
    m_cache_ip[slot] = ip;
    m_cache_mac[slot] = mac;
    m_cache_valid[slot] = 1'b1;
  endtask

  task automatic classify_frame(ref out_item_t r);
    int len, hl, iplen;
    logic [15:0] et;
    logic [31:0] src;
    logic [7:0] proto;
    len = m_byte_count;
    m_frame_counter = m_frame_counter + 1;
    if (len < 14) begin
      r.verdict = V_SHORT;
      return;
    end
    et = m_eth[15:0];
    if (et == EtArp) begin
      if (len < 42) begin
        r.verdict = V_ARP_SHORT;
        return;
      end
      r.verdict = V_ARP;
      r.src_ip = m_arp0[63:32];
      r.src_mac = m_arp1[47:0];
      if (m_arp1[63:48] == 16'd1 || m_arp1[63:48] == 16'd2)
        learn_addr(m_arp0[63:32], m_arp1[47:0]);
      if (m_arp1[63:48] == 16'd1 && m_arp0[31:0] == m_local_ip) r.send_arp_reply = 1'b1;
      return;
    end
    if (et != EtIpv4) begin
      r.verdict = V_NOT_IP;
      return;
    end
    if (len < 34) begin
      r.verdict = V_BAD_LEN;
      return;
    end
    hl = int'(m_ip1[27:24]) * 4;
    iplen = int'(m_ip1[23:8]);
    if (hl < 20 || len < 14 + hl || iplen < hl || 14 + iplen > len) begin
      r.verdict = V_BAD_LEN;
      return;
    end
    src = m_ip0[63:32];
    proto = m_ip1[7:0];
    r.src_ip = src;
    r.src_mac = m_eth[63:16];
    r.payload_offset = 7'(14 + hl);
    r.payload_len = 12'(iplen - hl);
    if (m_ip0[31:0] != m_local_ip) begin
      r.verdict = V_NOT_OURS;
      return;
    end
    learn_addr(src, m_eth[63:16]);
    if (proto == 8'd1) begin
      r.verdict = V_ICMP;
      if (iplen - hl >= 8 && m_icmp[23:16] == 8'd0 && m_wait_flag &&
          src == m_wait_target && m_icmp[15:0] == EchoId) begin
        m_wait_flag = 1'b0;
        r.echo_matched = 1'b1;
      end
    end else if (proto == 8'd17) begin
      r.verdict = V_UDP;
    end else if (proto == 8'd6) begin
      r.verdict = V_TCP;
    end else begin
      r.verdict = V_OTHER;
    end
  endtask

  task automatic predict_item(in_item_t it);
    out_item_t r;
    r = '0;
    case (op_t'(it.op))
      OP_ARM: begin
        m_wait_target = it.query_ip;
        m_wait_flag = 1'b1;
        return;
      end
      OP_CANCEL: begin
        m_wait_flag = 1'b0;
        return;
      end
      OP_LOOKUP: begin
        r.verdict = V_LOOKUP;
        for (int i = 0; i < CacheEntries; i++) begin
          if (m_cache_valid[i] && m_cache_ip[i] == it.query_ip) begin
            r.lookup_hit = 1'b1;
            r.lookup_mac = m_cache_mac[i];
            break;
          end
        end
        r.echo_waiting = m_wait_flag;
        r.frames_seen = m_frame_counter;
        expected_verdicts.push_back(r);
        return;
      end
      default: begin
        if (m_byte_count < MaxFrameLen) begin
          capture_byte(m_byte_count, it.data_byte);
          m_byte_count++;
        end
        if (!it.last) return;
        classify_frame(r);
        r.echo_waiting = m_wait_flag;
        r.frames_seen = m_frame_counter;
        clear_frame_fields();
        expected_verdicts.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result verdict", out_data.verdict, 0);
      end else begin
        e = expected_verdicts.pop_front();
        verdicts_checked++;
        if (out_data.verdict !== e.verdict) report_mismatch("verdict", out_data.verdict, e.verdict);
        if (out_data.src_ip !== e.src_ip) report_mismatch("src_ip", out_data.src_ip, e.src_ip);
        if (out_data.src_mac !== e.src_mac) report_mismatch("src_mac", out_data.src_mac, e.src_mac);
        if (out_data.send_arp_reply !== e.send_arp_reply)
          report_mismatch("send_arp_reply", out_data.send_arp_reply, e.send_arp_reply);
        if (out_data.echo_matched !== e.echo_matched)
          report_mismatch("echo_matched", out_data.echo_matched, e.echo_matched);
        if (out_data.payload_offset !== e.payload_offset)
          report_mismatch("payload_offset", out_data.payload_offset, e.payload_offset);
        if (out_data.payload_len !== e.payload_len)
          report_mismatch("payload_len", out_data.payload_len, e.payload_len);
        if (out_data.lookup_hit !== e.lookup_hit)
          report_mismatch("lookup_hit", out_data.lookup_hit, e.lookup_hit);
        if (out_data.lookup_mac !== e.lookup_mac)
          report_mismatch("lookup_mac", out_data.lookup_mac, e.lookup_mac);
        if (out_data.echo_waiting !== e.echo_waiting)
          report_mismatch("echo_waiting", out_data.echo_waiting, e.echo_waiting);
        if (out_data.frames_seen !== e.frames_seen)
          report_mismatch("frames_seen", out_data.frames_seen, e.frames_seen);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("eth_arp_ipv4_rx_classifier test failed");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic send_op(op_t op, logic [31:0] ip);
    in_item_t it;
    it.op = op;
    it.data_byte = 8'($urandom);
    it.last = 1'($urandom);
    it.query_ip = ip;
    send_item(it);
  endtask

  task automatic send_frame(logic [7:0] bytes[$]);
    in_item_t it;
    for (int i = 0; i < bytes.size(); i++) begin
      it.op = OP_BYTE;
      it.data_byte = bytes[i];
      it.last = (i == bytes.size() - 1);
      it.query_ip = $urandom;
      send_item(it);
      // ops may slip between bytes
      if (!it.last && $urandom_range(99) < 2) send_op(op_t'($urandom_range(1, 3)), $urandom);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_local_ip(logic [31:0] ip);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= ip;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_local_ip = ip;
  endtask

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(5))
      0: return m_local_ip;
      1: return m_wait_target;
      2: return m_cache_ip[$urandom_range(CacheEntries - 1)];
      3: return 32'h0A000000 | $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic build_arp(ref logic [7:0] f[$], input logic [15:0] aop,
                           input logic [31:0] sip, input logic [47:0] smac,
                           input logic [31:0] tip, input int len);
    f.delete();
    for (int i = 0; i < len; i++) f.push_back(8'($urandom));
    if (len > 13) begin
      f[12] = EtArp[15:8];
      f[13] = EtArp[7:0];
    end
    for (int i = 0; i < 2; i++) if (20 + i < len) f[20 + i] = aop[15 - 8 * i -: 8];
    for (int i = 0; i < 6; i++) if (22 + i < len) f[22 + i] = smac[47 - 8 * i -: 8];
    for (int i = 0; i < 4; i++) begin
      if (28 + i < len) f[28 + i] = sip[31 - 8 * i -: 8];
      if (38 + i < len) f[38 + i] = tip[31 - 8 * i -: 8];
    end
  endtask

  task automatic build_ipv4(ref logic [7:0] f[$], input logic [3:0] ihl,
                            input int paylen, input logic [7:0] proto,
                            input logic [31:0] sip, input logic [31:0] dip,
                            input logic [47:0] smac, input logic [7:0] icmp_type,
                            input logic [15:0] icmp_id, input int extra);
    int hl, tot;
    hl = int'(ihl) * 4;
    tot = hl + paylen;
    f.delete();
    for (int i = 0; i < ((14 + tot + extra < 34) ? 34 : 14 + tot + extra); i++)
      f.push_back(8'($urandom));
    for (int i = 0; i < 6; i++) f[6 + i] = smac[47 - 8 * i -: 8];
    f[12] = EtIpv4[15:8];
    f[13] = EtIpv4[7:0];
    f[14] = {4'h4, ihl};
    f[16] = tot[15:8];
    f[17] = tot[7:0];
    f[23] = proto;
    for (int i = 0; i < 4; i++) begin
      f[26 + i] = sip[31 - 8 * i -: 8];
      f[30 + i] = dip[31 - 8 * i -: 8];
    end
    if (14 + hl < f.size()) f[14 + hl] = icmp_type;
    if (18 + hl < f.size()) f[18 + hl] = icmp_id[15:8];
    if (19 + hl < f.size()) f[19 + hl] = icmp_id[7:0];
  endtask

  task automatic test_directed();
    logic [7:0] f[$];
    logic [31:0] peer;
    peer = 32'h0A000202;
    f = '{8'h00};
    send_frame(f);
    build_arp(f, 16'd1, 32'h0A000203, 48'hFFFFFFFFFFFF, m_local_ip, 30);
    send_frame(f);
    build_arp(f, 16'd1, peer, 48'h525400123502, m_local_ip, 42);
    send_frame(f);
    build_arp(f, 16'd2, 32'hFFFFFFFF, 48'h000000000000, 32'h0, 60);
    send_frame(f);
    build_arp(f, 16'd3, 32'h01020304, 48'h112233445566, m_local_ip, 42);
    send_frame(f);
    for (int i = 0; i < 4; i++) begin
      build_arp(f, 16'd2, 32'hC0A80000 + i, {16'h0200, 32'(i)}, 32'h0, 42);
      send_frame(f);
    end
    send_op(OP_LOOKUP, peer);
    send_op(OP_LOOKUP, 32'hC0A80003);
    send_op(OP_LOOKUP, 32'h0);
    f = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
          8'h0A, 8'h0B, 8'h86, 8'hDD, 8'h60};
    send_frame(f);
    build_ipv4(f, 4'd5, 8, 8'd1, peer, m_local_ip, 48'h525400123502, 8'd0, 16'h0, 0);
    f = f[0:29];
    send_frame(f);
    build_ipv4(f, 4'd4, 8, 8'd1, peer, m_local_ip, 48'h525400123502, 8'd0, 16'h0, 0);
    send_frame(f);
    send_op(OP_ARM, peer);
    build_ipv4(f, 4'd5, 8, 8'd1, peer, m_local_ip, 48'h525400123502, 8'd0, EchoId, 0);
    send_frame(f);
    send_op(OP_ARM, peer);
    send_op(OP_CANCEL, 32'h0);
    build_ipv4(f, 4'd15, 0, 8'd17, peer, m_local_ip, 48'h1, 8'd0, EchoId, 3);
    send_frame(f);
    build_ipv4(f, 4'd5, 20, 8'd6, peer, 32'h08080808, 48'h2, 8'd0, 16'h0, 0);
    send_frame(f);
    build_ipv4(f, 4'd5, 100, 8'd6, peer, m_local_ip, 48'h3, 8'd0, 16'h0, 40);
    send_frame(f);
    build_ipv4(f, 4'd5, 4, 8'd255, peer, m_local_ip, 48'h4, 8'd0, 16'h0, 0);
    send_frame(f);
    send_op(OP_LOOKUP, peer);
  endtask

  task automatic test_random(int frames);
    logic [7:0] f[$];
    logic [31:0] dip, sip;
    int kind;
    for (int n = 0; n < frames; n++) begin
      kind = $urandom_range(99);
      sip = pick_ip();
      dip = ($urandom_range(3) != 0) ? m_local_ip : pick_ip();
      if (kind < 10) begin
        send_op(op_t'($urandom_range(1, 3)), pick_ip());
      end else if (kind < 30) begin
        build_arp(f, 16'($urandom_range(0, 3)), sip, {$urandom, 16'($urandom)}, dip,
                  ($urandom_range(9) == 0) ? $urandom_range(14, 45) : 42);
        send_frame(f);
      end else if (kind < 85) begin
        if ($urandom_range(2) == 0) begin
          send_op(OP_ARM, sip);
        end
        build_ipv4(f, ($urandom_range(7) == 0) ? 4'($urandom) : 4'd5,
                   $urandom_range(0, 12), (kind < 60) ? 8'd1 : 8'($urandom_range(0, 20)),
                   sip, dip, {$urandom, 16'($urandom)}, 8'($urandom_range(1)),
                   ($urandom_range(3) != 0) ? EchoId : 16'($urandom), $urandom_range(0, 2));
        if ($urandom_range(9) == 0) f = f[0:$urandom_range(f.size() - 1)];
        send_frame(f);
      end else begin
        f.delete();
        for (int i = 0; i < $urandom_range(1, 40); i++) f.push_back(8'($urandom));
        send_frame(f);
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 6;
    recv_idle_pct = 67;
    test_directed();
    write_local_ip(32'h00000000);
    test_random(6);
    write_local_ip(32'hFFFFFFFF);
    test_random(6);
    write_local_ip(32'hC0A80001);
    send_idle_pct = 67;
    recv_idle_pct = 6;
    test_random(6);
    write_local_ip(LocalIpReset);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(6);
    wait_drained();
    $display("covered arp, ipv4, icmp echo wait, cache lookups and %0d checked results",
             verdicts_checked);
    $display("local_ip taken through zero, all ones and two ordinary addresses");
    if (mismatches == 0) begin
      $display("eth_arp_ipv4_rx_classifier test passed");
    end else begin
      $display("eth_arp_ipv4_rx_classifier test failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/earc_pkg.sv
hdl/earc_cache.sv
hdl/eth_arp_ipv4_rx_classifier.sv
hdl/earc_checker.sv
tb/tb_eth_arp_ipv4_rx_classifier.sv
